// ===== hdl/gwna_pkg.sv =====
// gwna_pkg: shared constants, types and arithmetic helpers for the aggregation block
`default_nettype none

package gwna_pkg;

	// store geometry
	localparam int FEATURE_SLOTS = 256;
	localparam int LANES         = 4;
	localparam int FIELD_LANES   = 4;
	localparam int ACT_LANES     = (LANES < FIELD_LANES) ? LANES : FIELD_LANES;
	localparam int DEPTH         = (FEATURE_SLOTS / LANES > 0) ? FEATURE_SLOTS / LANES : 1;
	localparam int ROW_W         = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// field widths
	localparam int CHUNK_W  = 6;
	localparam int WEIGHT_W = 16;
	localparam int FEAT_W   = 16;
	localparam int PROD_W   = 32;
	localparam int ACC_W    = 40;

	typedef logic [CHUNK_W-1:0]         chunk_t;
	typedef logic [WEIGHT_W-1:0]        weight_t;
	typedef logic signed [FEAT_W-1:0]   feat_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [ACC_W-1:0]    acc_t;
	typedef logic [ROW_W-1:0]           row_t;

	localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	// per-cycle pipeline control shared by all lanes
	typedef struct packed {
		logic accept;   // new beat read from the lane stores
		logic adv;      // stage 1 moves into stage 2
		logic wr;       // stage 2 writes back
		logic hit_acc;  // new beat reads the row being written back
		logic hit_adv;  // stage 1 beat uses the row being written back
		logic first_s2; // stage 2 beat overwrites
		row_t row_in;
		row_t row_wb;
	} ctl_t;

	// row of a chunk inside each lane store, wrapping modulo the depth
	function automatic row_t row_of(input chunk_t chunk);
		logic [CHUNK_W+ROW_W-1:0] wide;
		wide = {{ROW_W{1'b0}}, chunk};
		return wide[ROW_W-1:0];
	endfunction

	// saturating accumulate of an exact product
	function automatic acc_t sat_add(input acc_t acc, input prod_t prod);
		logic signed [ACC_W:0] s;
		s = {acc[ACC_W-1], acc} + {{(ACC_W+1-PROD_W){prod[PROD_W-1]}}, prod};
		if (s[ACC_W] != s[ACC_W-1]) begin
			return s[ACC_W] ? ACC_MIN : ACC_MAX;
		end
		return s[ACC_W-1:0];
	endfunction

	function automatic acc_t widen(input prod_t prod);
		return {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
	endfunction

endpackage

`default_nettype wire

// ===== hdl/gwna_in_if.sv =====
// gwna_in_if: input channel carrying one feature chunk and its weight per beat
`default_nettype none

interface gwna_in_if;
	import gwna_pkg::*;

	logic    valid;
	logic    ready;
	chunk_t  chunk_index;
	weight_t weight;
	feat_t   feat_lane0;
	feat_t   feat_lane1;
	feat_t   feat_lane2;
	feat_t   feat_lane3;
	logic    first_of_vertex;
	logic    last_of_vertex;

	modport source (
		output valid, chunk_index, weight, feat_lane0, feat_lane1, feat_lane2, feat_lane3,
		output first_of_vertex, last_of_vertex,
		input  ready
	);

	modport sink (
		input  valid, chunk_index, weight, feat_lane0, feat_lane1, feat_lane2, feat_lane3,
		input  first_of_vertex, last_of_vertex,
		output ready
	);
endinterface

`default_nettype wire

// ===== hdl/gwna_out_if.sv =====
// gwna_out_if: output channel carrying the four chunk sums per beat
`default_nettype none

interface gwna_out_if;
	import gwna_pkg::*;

	logic   valid;
	logic   ready;
	chunk_t out_chunk;
	acc_t   sum_lane0;
	acc_t   sum_lane1;
	acc_t   sum_lane2;
	acc_t   sum_lane3;

	modport source (
		output valid, out_chunk, sum_lane0, sum_lane1, sum_lane2, sum_lane3,
		input  ready
	);

	modport sink (
		input  valid, out_chunk, sum_lane0, sum_lane1, sum_lane2, sum_lane3,
		output ready
	);
endinterface

`default_nettype wire

// ===== hdl/gcn_weighted_neighbor_aggregation.sv =====
// gcn_weighted_neighbor_aggregation: top level of the weighted neighbor sum stage
`default_nettype none

// Weighted neighbor aggregation, one chunk of four feature lanes per beat. Each lane
// multiplies its Q3.12 feature by the shared Q0.16 weight exactly and either stores
// the product (first beat of a vertex) or adds it into its Q11.28 accumulator with
// saturation at 40 bits; a beat marked last of vertex delivers the updated sums of
// its chunk. The block takes one beat every clock unless a waiting result holds it
// back: the lanes each own a 64-row store with one read and one write per cycle, and
// a bypass from the write-back stage keeps back-to-back beats on the same chunk
// coherent, so throughput is one item per cycle between such stalls. A beat is read
// and registered, multiplied, and accumulated into the output register. A result
// waiting on the output stalls a beat with a result to deliver and those behind it;
// other accumulate-only beats keep flowing. Accumulator rows come up undefined after
// reset, so each chunk must see a first-of-vertex beat before it is added into.
module gcn_weighted_neighbor_aggregation (
	input  wire logic  clk,
	input  wire logic  arst_n,
	gwna_in_if.sink    item,
	gwna_out_if.source result
);
	import gwna_pkg::*;

	// stage 1: fields registered, store read data available
	logic    v1_q;
	chunk_t  chunk_s1;
	weight_t weight_s1;
	logic    first_s1;
	logic    last_s1;

	// stage 2: product and accumulator operand registered
	logic    v2_q;
	chunk_t  chunk_s2;
	logic    first_s2;
	logic    last_s2;

	logic    out_free;
	logic    s2_free;
	logic    s1_free;
	logic    accept;
	logic    adv;
	logic    wr;
	logic    push;
	ctl_t    ctl;
	feat_t   feat_in [FIELD_LANES];
	acc_t    wb_sum  [FIELD_LANES];

	// stage 2 only waits when it has a result and the output register is full
	assign s2_free = !v2_q || !last_s2 || out_free;
	assign s1_free = !v1_q || s2_free;
	assign accept  = item.valid && s1_free;
	assign adv     = v1_q && s2_free;
	assign wr      = v2_q && s2_free;
	assign push    = wr && last_s2;

	assign item.ready = s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else begin
			if (accept) begin
				v1_q <= 1'b1;
			end else if (adv) begin
				v1_q <= 1'b0;
			end
			if (adv) begin
				v2_q <= 1'b1;
			end else if (wr) begin
				v2_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			chunk_s1  <= item.chunk_index;
			weight_s1 <= item.weight;
			first_s1  <= item.first_of_vertex;
			last_s1   <= item.last_of_vertex;
		end
		if (adv) begin
			chunk_s2 <= chunk_s1;
			first_s2 <= first_s1;
			last_s2  <= last_s1;
		end
	end

	// bypass the write-back value to beats that read the same row too early
	always_comb begin
		ctl.accept   = accept;
		ctl.adv      = adv;
		ctl.wr       = wr;
		ctl.row_in   = row_of(item.chunk_index);
		ctl.row_wb   = row_of(chunk_s2);
		ctl.hit_acc  = accept && wr && (row_of(item.chunk_index) == row_of(chunk_s2));
		ctl.hit_adv  = adv && wr && (row_of(chunk_s1) == row_of(chunk_s2));
		ctl.first_s2 = first_s2;
	end

	assign feat_in[0] = item.feat_lane0;
	assign feat_in[1] = item.feat_lane1;
	assign feat_in[2] = item.feat_lane2;
	assign feat_in[3] = item.feat_lane3;

	// lanes beyond the configured count read as zero
	for (genvar l = 0; l < FIELD_LANES; l++) begin : g_lane
		if (l < ACT_LANES) begin : g_on
			gwna_lane u_lane (
				.clk       (clk),
				.ctl       (ctl),
				.weight_s1 (weight_s1),
				.feat      (feat_in[l]),
				.sum       (wb_sum[l])
			);
		end else begin : g_off
			assign wb_sum[l] = '0;
		end
	end

	gwna_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.chunk_s2 (chunk_s2),
		.sums     (wb_sum),
		.free     (out_free),
		.result   (result)
	);

`ifndef SYNTHESIS
	// an accepted beat always occupies stage 1 next cycle
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v1_q)
		else $error("accepted beat lost before stage 1");

	// full pipe behind a blocked result must back-pressure the input
	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(v1_q && v2_q && !s2_free) |-> !item.ready)
		else $error("input taken while pipeline is full");

	// a held result blocks write-back of the next result beat
	a_held_result_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(v2_q && last_s2 && result.valid && !result.ready) |-> !wr)
		else $error("result beat written back over a waiting result");

	// output valid only rises from a write-back with a result
	a_result_from_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(push))
		else $error("result appeared without a write-back");
`endif

endmodule

`default_nettype wire

// ===== hdl/gwna_lane.sv =====
// gwna_lane: one lane store with multiply, saturating accumulate and write-back bypass
`default_nettype none

module gwna_lane (
	input  wire logic           clk,
	input  wire gwna_pkg::ctl_t ctl,
	input  wire gwna_pkg::weight_t weight_s1,
	input  wire gwna_pkg::feat_t feat,
	output gwna_pkg::acc_t       sum
);
	import gwna_pkg::*;

	acc_t  mem [DEPTH];
	acc_t  rd_s1;
	feat_t feat_s1;
	logic  fwd_hit_s1;
	acc_t  fwd_val_s1;
	acc_t  acc_cur;
	logic signed [PROD_W:0] prod_full;
	prod_t prod_s2;
	acc_t  acc_s2;

	// lane store, read before write
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			rd_s1 <= mem[ctl.row_in];
		end
		if (ctl.wr) begin
			mem[ctl.row_wb] <= sum;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			feat_s1    <= feat;
			fwd_hit_s1 <= ctl.hit_acc;
			fwd_val_s1 <= sum;
		end
		if (ctl.adv) begin
			prod_s2 <= prod_full[PROD_W-1:0];
			acc_s2  <= ctl.hit_adv ? sum : acc_cur;
		end
	end

	always_comb begin
		acc_cur   = fwd_hit_s1 ? fwd_val_s1 : rd_s1;
		prod_full = feat_s1 * $signed({1'b0, weight_s1});
		sum       = ctl.first_s2 ? widen(prod_s2) : sat_add(acc_s2, prod_s2);
	end

endmodule

`default_nettype wire

// ===== hdl/gwna_merge.sv =====
// gwna_merge: gathers the lane sums into the registered output beat
`default_nettype none

module gwna_merge (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire gwna_pkg::chunk_t chunk_s2,
	input  wire gwna_pkg::acc_t  sums [gwna_pkg::FIELD_LANES],
	output logic                 free,
	gwna_out_if.source           result
);
	import gwna_pkg::*;

	logic   valid_q;
	chunk_t chunk_q;
	acc_t   sum_q [FIELD_LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			chunk_q <= chunk_s2;
			sum_q   <= sums;
		end
	end

	assign free             = !valid_q || result.ready;
	assign result.valid     = valid_q;
	assign result.out_chunk = chunk_q;
	assign result.sum_lane0 = sum_q[0];
	assign result.sum_lane1 = sum_q[1];
	assign result.sum_lane2 = sum_q[2];
	assign result.sum_lane3 = sum_q[3];

endmodule

`default_nettype wire

// ===== bench/gwna_sum_checker.sv =====
// gwna_sum_checker: watches both channels, predicts the chunk sums and compares every result beat
`timescale 1ns / 1ps

module gwna_sum_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	gwna_in_if        item,
	gwna_out_if       result,
	output int        mismatches,
	output int        pending,
	output int        sums_checked
);
	import gwna_pkg::*;

	localparam longint SUM_HI = 64'sd549755813887;
	localparam longint SUM_LO = -SUM_HI - 64'sd1;

	typedef struct packed {
		chunk_t                  chunk;
		acc_t [FIELD_LANES-1:0]  lane;
	} chunk_sums_t;

	acc_t        acc_shadow [FEATURE_SLOTS];
	chunk_sums_t sums_due [$];
	int          err_count = 0;
	int          due_count = 0;
	int          sum_count = 0;

	assign mismatches   = err_count;
	assign pending      = due_count;
	assign sums_checked = sum_count;

	// exact product, then either overwrite or add with clamping at 40 bits
	function automatic acc_t lane_update(input acc_t old, input weight_t w, input feat_t f,
			input logic overwrite);
		longint wl;
		longint prod;
		longint total;
		wl   = longint'(w);
		prod = longint'(f) * wl;
		if (overwrite) begin
			return acc_t'(prod);
		end
		total = longint'(old) + prod;
		if (total > SUM_HI) begin
			total = SUM_HI;
		end else if (total < SUM_LO) begin
			total = SUM_LO;
		end
		return acc_t'(total);
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		chunk_sums_t got;
		chunk_sums_t want;
		feat_t       feats [FIELD_LANES];
		int          slot;
		if (!arst_n) begin
			sums_due.delete();
			for (int i = 0; i < FEATURE_SLOTS; i++) begin
				acc_shadow[i] = '0;
			end
			due_count <= 0;
		end else begin
			// result side first: a beat leaving now never belongs to a beat entering now
			if (result.valid && result.ready) begin
				got.chunk   = result.out_chunk;
				got.lane[0] = result.sum_lane0;
				got.lane[1] = result.sum_lane1;
				got.lane[2] = result.sum_lane2;
				got.lane[3] = result.sum_lane3;
				if (sums_due.size() == 0) begin
					$error("sum beat for chunk %0d with nothing outstanding", got.chunk);
					err_count++;
				end else begin
					want = sums_due.pop_front();
					sum_count++;
					if (got.chunk !== want.chunk) begin
						$error("out_chunk expected %0d got %0d", want.chunk, got.chunk);
						err_count++;
					end
					for (int l = 0; l < FIELD_LANES; l++) begin
						if (got.lane[l] !== want.lane[l]) begin
							$error("%s expected %0d got %0d", $sformatf("sum_lane%0d", l),
								want.lane[l], got.lane[l]);
							err_count++;
						end
					end
				end
			end
			if (item.valid && item.ready) begin
				feats[0]   = item.feat_lane0;
				feats[1]   = item.feat_lane1;
				feats[2]   = item.feat_lane2;
				feats[3]   = item.feat_lane3;
				want.chunk = item.chunk_index;
				for (int l = 0; l < FIELD_LANES; l++) begin
					want.lane[l] = '0;
					if (l < LANES) begin
						slot = (int'(item.chunk_index) * LANES + l) % FEATURE_SLOTS;
						acc_shadow[slot] = lane_update(acc_shadow[slot], item.weight, feats[l],
							item.first_of_vertex);
						want.lane[l] = acc_shadow[slot];
					end
				end
				if (item.last_of_vertex) begin
					sums_due.insert(sums_due.size(), want);
				end
			end
			due_count <= sums_due.size();
		end
	end

endmodule

// ===== bench/tb.sv =====
// tb: stimulus, handshake pacing and verdict for the weighted neighbor aggregation block
`timescale 1ns / 1ps

module tb;
	import gwna_pkg::*;

	// generous ceiling: ~920 beats with random idle time between them plus the output hold-off
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	// settle time at the end, after the last predicted sum has been delivered
	localparam int TAIL_CYCLES = 12;

	typedef struct packed {
		chunk_t                  chunk;
		weight_t                 weight;
		feat_t [FIELD_LANES-1:0] feat;
		logic                    first;
		logic                    last;
	} beat_t;

	logic clk;
	logic arst_n;

	gwna_in_if  item_ch ();
	gwna_out_if result_ch ();

	int mismatches;
	int pending;
	int sums_checked;

	// pacing knobs: the sender's idle rate is only used by the stimulus process
	int        tx_idle_pct = 0;
	int        rx_idle_pct = 0;
	logic      hold_req    = 1'b0;
	logic [63:0] chunk_written = '0;
	int        beats_sent  = 0;
	int        cycle_count = 0;

	gcn_weighted_neighbor_aggregation dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	gwna_sum_checker sum_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item_ch),
		.result       (result_ch),
		.mismatches   (mismatches),
		.pending      (pending),
		.sums_checked (sums_checked)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d sums still outstanding", cycle_count, pending);
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver: random back-pressure, plus one long hold-off on request
	initial begin
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				// keep ready low long enough for the block to fill and push back on its input
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req <= 1'b0;
			end
			result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	function automatic beat_t make_beat(input chunk_t c, input weight_t w, input feat_t f0,
			input feat_t f1, input feat_t f2, input feat_t f3, input logic first,
			input logic last);
		beat_t b;
		b.chunk   = c;
		b.weight  = w;
		b.feat[0] = f0;
		b.feat[1] = f1;
		b.feat[2] = f2;
		b.feat[3] = f3;
		b.first   = first;
		b.last    = last;
		return b;
	endfunction

	// features lean on the extremes so that sums move fast and every bit toggles
	function automatic feat_t rand_feat();
		case ($urandom_range(0, 5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'sh0000;
			default: return feat_t'($urandom);
		endcase
	endfunction

	function automatic beat_t random_beat(input int c, input logic first, input logic last);
		weight_t w;
		case ($urandom_range(0, 5))
			0: w = 16'h0000;
			1: w = 16'hFFFF;
			2: w = 16'h8000;
			default: w = weight_t'($urandom);
		endcase
		return make_beat(chunk_t'(c), w, rand_feat(), rand_feat(), rand_feat(), rand_feat(),
			first, last);
	endfunction

	// offer one beat, with random idle cycles ahead of it, and wait for the handshake
	task automatic send_beat(input beat_t b);
		// a chunk that was never overwritten must start with its self term
		if (!chunk_written[b.chunk]) begin
			b.first = 1'b1;
		end
		while ($urandom_range(99) < tx_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid           <= 1'b1;
		item_ch.chunk_index     <= b.chunk;
		item_ch.weight          <= b.weight;
		item_ch.feat_lane0      <= b.feat[0];
		item_ch.feat_lane1      <= b.feat[1];
		item_ch.feat_lane2      <= b.feat[2];
		item_ch.feat_lane3      <= b.feat[3];
		item_ch.first_of_vertex <= b.first;
		item_ch.last_of_vertex  <= b.last;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		if (b.first) begin
			chunk_written[b.chunk] = 1'b1;
		end
		beats_sent++;
	endtask

	// stop offering and wait until every predicted sum has been delivered
	task automatic drain();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// mostly well-formed vertex chunks (self term, neighbors, last), some noise and
	// some pairs of chunks interleaved so the write-back bypass sees other rows in flight
	task automatic stream_vertices(input int budget);
		int start;
		int kind;
		int c;
		int d;
		int n;
		start = beats_sent;
		while (beats_sent - start < budget) begin
			kind = $urandom_range(0, 9);
			c    = $urandom_range(0, 63);
			if (kind < 7) begin
				n = $urandom_range(0, 6);
				send_beat(random_beat(c, 1'b1, n == 0));
				for (int k = 1; k <= n; k++) begin
					send_beat(random_beat(c, 1'b0, k == n));
				end
			end else if (kind < 9) begin
				// broken sequences: stray flags, repeated self terms, dangling chunks
				send_beat(random_beat(c, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
			end else begin
				d = (c + 1 + $urandom_range(0, 62)) % 64;
				n = $urandom_range(1, 4);
				send_beat(random_beat(c, 1'b1, 1'b0));
				send_beat(random_beat(d, 1'b1, 1'b0));
				for (int k = 0; k < n; k++) begin
					send_beat(random_beat(c, 1'b0, 1'b0));
					send_beat(random_beat(d, 1'b0, 1'b0));
				end
				send_beat(random_beat(c, 1'b0, 1'b1));
				send_beat(random_beat(d, 1'b0, 1'b1));
			end
		end
	endtask

	initial begin : stimulus
		int c;
		arst_n                  <= 1'b0;
		item_ch.valid           <= 1'b0;
		item_ch.chunk_index     <= '0;
		item_ch.weight          <= '0;
		item_ch.feat_lane0      <= '0;
		item_ch.feat_lane1      <= '0;
		item_ch.feat_lane2      <= '0;
		item_ch.feat_lane3      <= '0;
		item_ch.first_of_vertex <= 1'b0;
		item_ch.last_of_vertex  <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first mix: sender mostly busy, receiver mostly stalling
		tx_idle_pct =  30;
		rx_idle_pct <= 70;

		// directed: extreme features and weights, self term emitted at once
		send_beat(make_beat(6'd0, 16'hFFFF, 16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF,
			1'b1, 1'b1));
		// zero weight self term, then a full-scale add, then a unit add that emits
		send_beat(make_beat(6'd63, 16'h0000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000,
			1'b1, 1'b0));
		send_beat(make_beat(6'd63, 16'hFFFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
			1'b0, 1'b0));
		send_beat(make_beat(6'd63, 16'h0001, 16'sh0001, 16'shFFFF, 16'sh1234, 16'shEDCC,
			1'b0, 1'b1));
		send_beat(make_beat(6'd0, 16'h8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
			1'b1, 1'b1));
		// back-to-back adds on one chunk exercise the bypass path
		send_beat(make_beat(6'd1, 16'hFFFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
			1'b1, 1'b0));
		send_beat(make_beat(6'd1, 16'hFFFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
			1'b0, 1'b0));
		send_beat(make_beat(6'd1, 16'hFFFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF,
			1'b0, 1'b0));
		send_beat(make_beat(6'd1, 16'hFFFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
			1'b0, 1'b0));
		send_beat(make_beat(6'd1, 16'h0001, 16'sh0001, 16'sh0001, 16'shFFFF, 16'shFFFF,
			1'b0, 1'b1));
		// two chunks interleaved, one emitted while the other is still open
		send_beat(make_beat(6'd2, 16'h1234, 16'sh0F0F, 16'shF0F0, 16'sh7FFF, 16'sh8000,
			1'b1, 1'b0));
		send_beat(make_beat(6'd3, 16'h4321, 16'shF0F0, 16'sh0F0F, 16'sh8000, 16'sh7FFF,
			1'b1, 1'b0));
		send_beat(make_beat(6'd2, 16'hFFFF, 16'sh0001, 16'sh8000, 16'sh7FFF, 16'sh0000,
			1'b0, 1'b0));
		send_beat(make_beat(6'd3, 16'hFFFF, 16'sh8000, 16'sh0001, 16'sh0000, 16'sh7FFF,
			1'b0, 1'b1));
		send_beat(make_beat(6'd2, 16'h0100, 16'sh1000, 16'shF000, 16'sh0000, 16'sh0000,
			1'b0, 1'b1));
		// all-zero features and alternating bit patterns
		send_beat(make_beat(6'd0, 16'hFFFF, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
			1'b1, 1'b1));
		send_beat(make_beat(6'd32, 16'hAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA,
			1'b1, 1'b1));
		send_beat(make_beat(6'd32, 16'h5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555,
			1'b0, 1'b1));

		stream_vertices(220);

		// sender stays quiet until every outstanding sum has been delivered
		drain();

		// second mix: sender mostly idle, receiver mostly ready
		tx_idle_pct =  70;
		rx_idle_pct <= 30;
		stream_vertices(220);

		// long receiver hold-off while the sender keeps offering mostly emitting beats,
		// so the output register fills and the input gets pushed back
		tx_idle_pct = 0;
		hold_req    <= 1'b1;
		for (int k = 0; k < 60; k++) begin
			send_beat(random_beat($urandom_range(0, 63), 1'($urandom_range(0, 1)),
				$urandom_range(0, 4) != 0));
		end
		drain();

		// no idling on either side from here on
		rx_idle_pct <= 0;

		// drive one chunk into both saturation bounds, then pull back off them;
		// lane 2 stays random so it wanders without clamping
		c = $urandom_range(0, 63);
		send_beat(make_beat(chunk_t'(c), 16'hFFFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
			1'b1, 1'b0));
		for (int k = 1; k <= 300; k++) begin
			send_beat(make_beat(chunk_t'(c), 16'hFFFF, 16'sh7FFF, 16'sh8000, rand_feat(),
				16'sh8000, 1'b0, (k % 32) == 0));
		end
		for (int k = 1; k <= 20; k++) begin
			send_beat(make_beat(chunk_t'(c), 16'hFFFF, 16'sh8000, 16'sh7FFF, rand_feat(),
				16'sh7FFF, 1'b0, (k % 4) == 0));
		end

		stream_vertices(80);

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run covered %0d input beats and %0d checked sum beats", beats_sent,
			sums_checked);
		$display("across three pacing mixes, an output hold-off and a saturation sweep");
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
